>>> rtl/frc_pkg.sv
// Package for the frame receive checker.
// Holds frame layout constants and the byte kind and status codes.
// No dependencies.
`default_nettype none

package frc_pkg;

  localparam int unsigned POS_W       = 17;
  localparam int unsigned LEN_W       = 16;
  localparam logic [7:0]  SEED_RESET  = 8'd42;
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
  localparam logic [POS_W-1:0] HEADER_BYTES = POS_W'(3);

  typedef logic [1:0] kind_t;
  typedef logic [1:0] status_t;

  localparam kind_t KIND_COMMAND = 2'd0;
  localparam kind_t KIND_LENGTH  = 2'd1;
  localparam kind_t KIND_PAYLOAD = 2'd2;
  localparam kind_t KIND_TRAILER = 2'd3;

  localparam status_t STATUS_OK        = 2'd0;
  localparam status_t STATUS_SHORT     = 2'd1;
  localparam status_t STATUS_LEN_ERR   = 2'd2;
  localparam status_t STATUS_CHECK_ERR = 2'd3;

endpackage

`default_nettype wire

>>> rtl/frc_rx_if.sv
// Receive channel of the frame receive checker: one frame byte per item.
// Valid/ready handshake. No dependencies.
`default_nettype none

interface frc_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       rx_last;

  modport source (output valid, output rx_byte, output rx_last, input ready);
  modport sink   (input valid, input rx_byte, input rx_last, output ready);
endinterface

`default_nettype wire

>>> rtl/frc_tx_if.sv
// Result channel of the frame receive checker: tagged byte and verdict per item.
// Valid/ready handshake; uses frc_pkg for the code types.
`default_nettype none

interface frc_tx_if
  import frc_pkg::*;
;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  kind_t      byte_kind;
  logic       frame_done;
  status_t    frame_status;
  logic [7:0] frame_command;

  modport source (output valid, output out_byte, output byte_kind, output frame_done,
                  output frame_status, output frame_command, input ready);
  modport sink   (input valid, input out_byte, input byte_kind, input frame_done,
                  input frame_status, input frame_command, output ready);
endinterface

`default_nettype wire

>>> rtl/frame_receive_checker.sv
// Frame receive checker top level.
// Depends on frc_pkg, frc_rx_if and frc_tx_if.
//
// Usage:
//   rx carries received bytes, one per item, with rx_last on the final byte
//   of a frame (command, 16-bit little-endian length, payload, checksum).
//   tx returns one item per received byte: the byte, its kind, and on the
//   last byte frame_done with the verdict (ok, too short, length mismatch,
//   checksum mismatch). Payload bytes leave before the verdict; drop them
//   downstream when the verdict is an error.
//   cfg_we/cfg_wdata write the checksum seed; it applies from the next frame.
// Timing:
//   tx valid rises in the cycle after rx acceptance. While tx.ready stays high,
//   one byte per cycle is sustained; the single tx output register sets that figure.
// Reset (rst, synchronous): frame position, length and command clear, the
//   seed and running sum return to 42, tx empties.
// Stall: while tx holds an untaken item, rx.ready is low; an item is taken
//   in the same cycle that the held one leaves.
`default_nettype none

module frame_receive_checker
  import frc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata,
  frc_rx_if.sink          rx,
  frc_tx_if.source        tx
);

  logic [7:0]       checksum_seed;
  logic [POS_W-1:0] byte_position;
  logic [LEN_W-1:0] declared_length;
  logic [7:0]       running_sum;
  logic [7:0]       held_command;

  logic [POS_W-1:0] byte_position_next;
  logic [LEN_W-1:0] declared_length_next;
  logic [7:0]       running_sum_next;
  logic [7:0]       held_command_next;
  kind_t            kind_next;
  status_t          status_next;

  logic             out_valid;
  logic [7:0]       out_byte;
  kind_t            byte_kind;
  logic             frame_done;
  status_t          frame_status;
  logic [7:0]       frame_command;

  logic             accept;
  logic [POS_W-1:0] payload_end;
  logic [POS_W:0]   total;
  logic [POS_W:0]   expected;

  assign rx.ready = !out_valid || tx.ready;
  assign accept   = rx.valid && rx.ready;

  assign payload_end = HEADER_BYTES + POS_W'(declared_length);

  always_comb begin
    held_command_next    = held_command;
    declared_length_next = declared_length;
    running_sum_next     = running_sum;
    kind_next            = KIND_TRAILER;
    if (byte_position == '0) begin
      kind_next         = KIND_COMMAND;
      held_command_next = rx.rx_byte;
      running_sum_next  = checksum_seed;
    end else if (byte_position == POS_W'(1)) begin
      kind_next            = KIND_LENGTH;
      declared_length_next = LEN_W'(rx.rx_byte);
      running_sum_next     = running_sum + rx.rx_byte;
    end else if (byte_position == POS_W'(2)) begin
      kind_next            = KIND_LENGTH;
      declared_length_next = {rx.rx_byte, declared_length[7:0]};
      running_sum_next     = running_sum + rx.rx_byte;
    end else if (byte_position < payload_end) begin
      kind_next        = KIND_PAYLOAD;
      running_sum_next = running_sum + rx.rx_byte;
    end
  end

  assign total    = {1'b0, byte_position} + (POS_W+1)'(1);
  assign expected = (POS_W+1)'(declared_length_next) + (POS_W+1)'(4);

  always_comb begin
    status_next = STATUS_OK;
    if (rx.rx_last) begin
      if (total <= (POS_W+1)'(HEADER_BYTES)) begin
        status_next = STATUS_SHORT;
      end else if (total != expected) begin
        status_next = STATUS_LEN_ERR;
      end else if (running_sum_next != rx.rx_byte) begin
        status_next = STATUS_CHECK_ERR;
      end
    end
  end

  always_comb begin
    byte_position_next = byte_position;
    if (rx.rx_last) begin
      byte_position_next = '0;
    end else if (byte_position != POS_MAX) begin
      byte_position_next = byte_position + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      checksum_seed   <= SEED_RESET;
      byte_position   <= '0;
      declared_length <= '0;
      running_sum     <= SEED_RESET;
      held_command    <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        checksum_seed <= cfg_wdata;
      end
      if (accept) begin
        byte_position   <= byte_position_next;
        declared_length <= rx.rx_last ? '0 : declared_length_next;
        running_sum     <= running_sum_next;
        held_command    <= held_command_next;
        out_valid       <= 1'b1;
      end else if (tx.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_byte      <= rx.rx_byte;
      byte_kind     <= kind_next;
      frame_done    <= rx.rx_last;
      frame_status  <= status_next;
      frame_command <= held_command_next;
    end
  end

  assign tx.valid         = out_valid;
  assign tx.out_byte      = out_byte;
  assign tx.byte_kind     = byte_kind;
  assign tx.frame_done    = frame_done;
  assign tx.frame_status  = frame_status;
  assign tx.frame_command = frame_command;

endmodule

`default_nettype wire
